// ===== sv/assert_macros.svh =====
// assertion macros shared by the odometry rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/twodo_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and functions of the tracking wheel odometry core
package twodo_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int STEP_W           = 5;
  localparam int SAT_W            = 72;
  localparam int CFG_W            = 21;

  localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
  localparam logic [32:0] PI_Q30      = 33'd3373259426;
  localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
  localparam logic [32:0] GAIN_Q30    = 33'd652032874;

  localparam logic OP_SAMPLE   = 1'b0;
  localparam logic OP_SET_POSE = 1'b1;

  localparam logic CFG_DIST        = 1'b0;
  localparam logic CFG_BACK_OFFSET = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] left_angle;
    logic signed [31:0] right_angle;
    logic signed [31:0] back_angle;
    logic signed [31:0] heading;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_heading;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading_out;
  } out_t;

  function automatic logic [29:0] atan_q30(input logic [STEP_W-1:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [31:0] r;
    if ((&v[SAT_W-1:31]) || !(|v[SAT_W-1:31])) begin
      r = v[31:0];
    end else if (v[SAT_W-1]) begin
      r = 32'sh80000000;
    end else begin
      r = 32'sh7fffffff;
    end
    return r;
  endfunction

endpackage

// ===== sv/tracking_wheel_odometry_core.sv =====
`timescale 1ns / 1ps
// Three-wheel odometry pose integrator.
// Input channel (in_valid / in_stall / in_word): one word per encoder sample
// (opcode sample) or per pose load (opcode set pose). A two-word queue takes
// words while the back end is busy; in_stall rises only when it is full.
// Output channel (out_valid / out_stall / out_word): exactly one result word
// per input word, in order, holding the pose and heading after that word.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 distance per degree, 1 back offset); write only while idle.
// A set pose passes from the queue straight to the output state. A sample
// passes through dispatch, the wheel and heading multiplies, a combine step,
// angle reduction (reciprocal estimate, multiply back, two corrections),
// a wrap step, CORDIC_STEPS rotation steps (capped at the 24 atan entries),
// the rotation multiplies and the output step. The multiplies share one
// multiplier, the rotation is an iterative cordic loop, and one sample is
// processed at a time.
// Reset clears the pose, the latched readings, the queue and out_valid;
// registers return to 1573 and 327680. While out_stall is high the result
// word holds and the back end waits with its next result.
module tracking_wheel_odometry_core #(
  parameter int FRAC_BITS    = twodo_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = twodo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  twodo_pkg::in_t               in_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output twodo_pkg::out_t              out_word,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [twodo_pkg::CFG_W-1:0]  cfg_data
);

  logic [15:0]    dist_per_deg;
  logic [20:0]    back_offset;
  logic           q_valid;
  twodo_pkg::in_t q_word;
  logic           pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_per_deg <= 16'd1573;
      back_offset  <= 21'd327680;
    end else if (cfg_we) begin
      unique case (cfg_index)
        twodo_pkg::CFG_DIST:        dist_per_deg <= cfg_data[15:0];
        twodo_pkg::CFG_BACK_OFFSET: back_offset  <= cfg_data[20:0];
        default: ;
      endcase
    end
  end

  twodo_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_word  (in_word),
    .push_stall (in_stall),
    .pop_valid  (q_valid),
    .pop_word   (q_word),
    .pop        (pop)
  );

  twodo_back #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .dist_per_deg (dist_per_deg),
    .back_offset  (back_offset),
    .q_valid      (q_valid),
    .q_word       (q_word),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word     (out_word)
  );

endmodule

// ===== sv/twodo_queue.sv =====
`timescale 1ns / 1ps
// two-entry word queue between the accepting front and the compute back end
module twodo_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  twodo_pkg::in_t   push_word,
  output logic             push_stall,
  output logic             pop_valid,
  output twodo_pkg::in_t   pop_word,
  input  logic             pop
);

  twodo_pkg::in_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_stall = (count == 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_word   = mem[rd_ptr];
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== sv/twodo_back.sv =====
`timescale 1ns / 1ps
// sequenced pose integration: wheel scaling, angle reduction, cordic, rotation
`include "assert_macros.svh"
module twodo_back #(
  parameter int FRAC_BITS    = twodo_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = twodo_pkg::CORDIC_STEPS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [15:0]    dist_per_deg,
  input  logic [20:0]    back_offset,
  input  logic           q_valid,
  input  twodo_pkg::in_t q_word,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output twodo_pkg::out_t out_word
);

  localparam int SHL    = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int SHR    = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int PROD_W = 68;
  localparam int EXT_W  = PROD_W + SHL;
  localparam int DW     = 50 + SHL;
  localparam int AW     = 34 + 30 - FRAC_BITS;
  localparam int QSH    = 96 - AW;
  localparam logic [63:0] RECIP = 64'h4000_0000_0000_0000 / 64'(twodo_pkg::TWO_PI_Q30);
  localparam int NSTEP  = (CORDIC_STEPS < twodo_pkg::ATAN_ENTRIES) ? CORDIC_STEPS
                                                                  : twodo_pkg::ATAN_ENTRIES;
  localparam int RW     = 36;
  localparam int CW     = 34;
  localparam int ACC_W  = 69;
  localparam int SW     = twodo_pkg::STEP_W;
  localparam int SAT_W  = twodo_pkg::SAT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_COMB = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_WRAP = 3'd4;
  localparam logic [2:0] S_ROT  = 3'd5;
  localparam logic [2:0] S_PROD = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]           state;
  logic [SW-1:0]        cnt;
  logic                 is_set;
  logic signed [32:0]   d_left, d_right, d_back, d_head;
  logic signed [31:0]   lh_old, hdg;
  logic signed [DW-1:0] dl, dr, db;
  logic signed [PROD_W-1:0] hb;
  logic signed [31:0]   fwd, side;
  logic                 neg;
  logic [AW-1:0]        mag;
  logic signed [33:0]   qe;
  logic signed [RW-1:0] z;
  logic signed [CW-1:0] x, y;
  logic                 flip;
  logic signed [ACC_W-1:0] acc_x, acc_y;
  logic signed [31:0]   last_left, last_right, last_back, last_heading;
  logic signed [31:0]   pose_x, pose_y;

  logic signed [33:0]       mul_a, mul_b;
  logic signed [PROD_W-1:0] mul;
  logic signed [EXT_W-1:0]  scaled;
  logic signed [CW-1:0]     s_v, c_v;
  logic signed [33:0]       mid;
  logic signed [AW-1:0]     angle;
  logic [AW-1:0]            sub;
  logic signed [RW-1:0]     r0, r1, r2, pi_s, two_pi_s, half_pi_s;
  logic                     fold;
  logic signed [31:0]       px_new, py_new;
  logic                     out_free;

  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == S_IDLE) && q_valid;

  assign s_v = flip ? -y : y;
  assign c_v = flip ? -x : x;

  // one shared multiplier, operands picked by the sequencer
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_MUL) begin
      case (cnt[1:0])
        2'd0: begin mul_a = 34'(d_left);  mul_b = signed'({18'd0, dist_per_deg}); end
        2'd1: begin mul_a = 34'(d_right); mul_b = signed'({18'd0, dist_per_deg}); end
        2'd2: begin mul_a = 34'(d_back);  mul_b = signed'({18'd0, dist_per_deg}); end
        default: begin mul_a = 34'(d_head); mul_b = signed'({13'd0, back_offset}); end
      endcase
    end else if (state == S_MOD) begin
      // turn count estimated by reciprocal, then multiplied back by 2*pi
      if (cnt[0]) begin
        mul_a = qe;
        mul_b = signed'({1'b0, twodo_pkg::TWO_PI_Q30});
      end else begin
        mul_a = signed'({1'b0, mag[AW-2:AW-34]});
        mul_b = signed'(34'(RECIP));
      end
    end else begin
      case (cnt[1:0])
        2'd0: begin mul_a = 34'(fwd);  mul_b = s_v; end
        2'd1: begin mul_a = 34'(side); mul_b = c_v; end
        2'd2: begin mul_a = 34'(fwd);  mul_b = c_v; end
        default: begin mul_a = 34'(side); mul_b = s_v; end
      endcase
    end
    mul = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  assign scaled = (EXT_W'(mul) <<< SHL) >>> SHR;

  assign mid   = 34'(lh_old) + 34'(d_head >>> 1);
  assign angle = AW'(mid) <<< (30 - FRAC_BITS);
  assign sub   = AW'(twodo_pkg::TWO_PI_Q30);

  assign pi_s      = signed'(RW'(twodo_pkg::PI_Q30));
  assign two_pi_s  = signed'(RW'(twodo_pkg::TWO_PI_Q30));
  assign half_pi_s = signed'(RW'(twodo_pkg::HALF_PI_Q30));

  // wrap into [-pi, pi], then fold into [-pi/2, pi/2] by a half turn
  always_comb begin
    r0 = neg ? -signed'(RW'(mag)) : signed'(RW'(mag));
    r1 = r0;
    if (r1 > pi_s) begin
      r1 = r1 - two_pi_s;
    end
    if (r1 < -pi_s) begin
      r1 = r1 + two_pi_s;
    end
    fold = 1'b0;
    r2   = r1;
    if (r1 > half_pi_s) begin
      r2   = r1 - pi_s;
      fold = 1'b1;
    end else if (r1 < -half_pi_s) begin
      r2   = r1 + pi_s;
      fold = 1'b1;
    end
  end

  assign px_new = is_set ? pose_x
                         : twodo_pkg::sat32(SAT_W'(pose_x) + SAT_W'(acc_x >>> 30));
  assign py_new = is_set ? pose_y
                         : twodo_pkg::sat32(SAT_W'(pose_y) + SAT_W'(acc_y >>> 30));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      last_left    <= '0;
      last_right   <= '0;
      last_back    <= '0;
      last_heading <= '0;
      pose_x       <= '0;
      pose_y       <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            is_set     <= (q_word.opcode == twodo_pkg::OP_SET_POSE);
            last_left  <= q_word.left_angle;
            last_right <= q_word.right_angle;
            last_back  <= q_word.back_angle;
            if (q_word.opcode == twodo_pkg::OP_SET_POSE) begin
              hdg          <= q_word.new_heading;
              last_heading <= q_word.new_heading;
              pose_x       <= q_word.new_x;
              pose_y       <= q_word.new_y;
              state        <= S_FIN;
            end else begin
              hdg          <= q_word.heading;
              d_left       <= 33'(q_word.left_angle) - 33'(last_left);
              d_right      <= 33'(q_word.right_angle) - 33'(last_right);
              d_back       <= 33'(last_back) - 33'(q_word.back_angle);
              d_head       <= 33'(q_word.heading) - 33'(last_heading);
              lh_old       <= last_heading;
              last_heading <= q_word.heading;
              cnt          <= '0;
              state        <= S_MUL;
            end
          end
        end
        S_MUL: begin
          case (cnt[1:0])
            2'd0: dl <= scaled[DW-1:0];
            2'd1: dr <= scaled[DW-1:0];
            2'd2: db <= scaled[DW-1:0];
            default: hb <= mul;
          endcase
          if (cnt == SW'(3)) begin
            state <= S_COMB;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_COMB: begin
          fwd   <= twodo_pkg::sat32((SAT_W'(dl) + SAT_W'(dr)) >>> 1);
          side  <= twodo_pkg::sat32(SAT_W'(db) + SAT_W'(hb >>> FRAC_BITS));
          neg   <= angle[AW-1];
          mag   <= angle[AW-1] ? AW'(-angle) : AW'(angle);
          cnt   <= '0;
          state <= S_MOD;
        end
        S_MOD: begin
          // the estimate is short by at most two turns, removed one per cycle
          case (cnt[1:0])
            2'd0: qe <= 34'(mul >>> QSH);
            2'd1: mag <= mag - AW'(mul);
            default: begin
              if (mag >= sub) begin
                mag <= mag - sub;
              end
            end
          endcase
          if (cnt == SW'(3)) begin
            state <= S_WRAP;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_WRAP: begin
          z     <= r2;
          flip  <= fold;
          x     <= signed'(CW'(twodo_pkg::GAIN_Q30));
          y     <= '0;
          cnt   <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          if (z >= 0) begin
            x <= x - (y >>> cnt);
            y <= y + (x >>> cnt);
            z <= z - signed'(RW'(twodo_pkg::atan_q30(cnt)));
          end else begin
            x <= x + (y >>> cnt);
            y <= y - (x >>> cnt);
            z <= z + signed'(RW'(twodo_pkg::atan_q30(cnt)));
          end
          if (cnt == SW'(NSTEP - 1)) begin
            cnt   <= '0;
            state <= S_PROD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_PROD: begin
          case (cnt[1:0])
            2'd0: acc_x <= ACC_W'(mul);
            2'd1: acc_x <= acc_x + ACC_W'(mul);
            2'd2: acc_y <= ACC_W'(mul);
            default: acc_y <= acc_y - ACC_W'(mul);
          endcase
          if (cnt == SW'(3)) begin
            state <= S_FIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_FIN: begin
          if (out_free) begin
            pose_x    <= px_new;
            pose_y    <= py_new;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      out_word.pos_x       <= px_new;
      out_word.pos_y       <= py_new;
      out_word.heading_out <= hdg;
    end
  end

  `ASSERT_IMPLIES(a_pop_idle, clk, rst, pop, state == S_IDLE, "queue popped while busy")
  `ASSERT_IMPLIES(a_rot_cnt, clk, rst, state == S_ROT, cnt < SW'(NSTEP), "cordic step overrun")
  `ASSERT_NEXT(a_fin_out, clk, rst, state == S_FIN && out_free, out_valid && state == S_IDLE, "result word not loaded")

endmodule

// ===== tb/sv/tracking_wheel_odometry_core_test.sv =====
`timescale 1ns / 1ps
// testbench of the odometry core: directed table, then random samples and pose loads against a predictor
module tracking_wheel_odometry_core_test;

  localparam int FB = 16;
  localparam int STEPS = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1400;

  localparam longint TWO_PI = 64'sd6746518852;
  localparam longint PI = 64'sd3373259426;
  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint GAIN = 64'sd652032874;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  twodo_pkg::in_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  twodo_pkg::out_t out_word;
  logic cfg_we = 1'b0;
  logic cfg_index = twodo_pkg::CFG_DIST;
  logic [twodo_pkg::CFG_W-1:0] cfg_data = '0;

  tracking_wheel_odometry_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  longint dist_per_deg, back_off;
  longint last_l, last_r, last_b, last_h, px, py;
  twodo_pkg::out_t expected_pose[$];
  int errors = 0;
  int idle_count = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_off = 1'b0;

  longint atan_tab[24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128};

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint travel(longint deg);
    longint p, hi, lo;
    p = deg * dist_per_deg;
    hi = floor_shift(p, 16) * (64'sd1 <<< FB);
    lo = ((p & 64'hFFFF) <<< FB) >>> 16;
    return hi + lo;
  endfunction

  function automatic void rotate_vec(input longint ang, output longint s, output longint c);
    longint r, x, y, nx;
    bit flip;
    r = (ang * (64'sd1 <<< (30 - FB))) % TWO_PI;
    x = GAIN;
    y = 0;
    flip = 1'b0;
    if (r > PI) r -= TWO_PI;
    if (r < -PI) r += TWO_PI;
    if (r > HALF_PI) begin
      r -= PI;
      flip = 1'b1;
    end else if (r < -HALF_PI) begin
      r += PI;
      flip = 1'b1;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      if (r >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        r -= atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        r += atan_tab[i];
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic twodo_pkg::out_t predict_pose(twodo_pkg::in_t w);
    twodo_pkg::out_t o;
    longint dl, dr, db, dh, fwd, side, mid, s, c;
    if (w.opcode == twodo_pkg::OP_SET_POSE) begin
      last_l = w.left_angle;
      last_r = w.right_angle;
      last_b = w.back_angle;
      last_h = w.new_heading;
      px = w.new_x;
      py = w.new_y;
      o.heading_out = w.new_heading;
    end else begin
      dl = travel(longint'(w.left_angle) - last_l);
      dr = travel(longint'(w.right_angle) - last_r);
      db = travel(last_b - longint'(w.back_angle));
      dh = longint'(w.heading) - last_h;
      fwd = clamp32((dl + dr) >>> 1);
      side = clamp32(db + ((dh * back_off) >>> FB));
      mid = last_h + (dh >>> 1);
      rotate_vec(mid, s, c);
      px = clamp32(px + ((fwd * s + side * c) >>> 30));
      py = clamp32(py + ((fwd * c - side * s) >>> 30));
      last_l = w.left_angle;
      last_r = w.right_angle;
      last_b = w.back_angle;
      last_h = w.heading;
      o.heading_out = w.heading;
    end
    o.pos_x = px[31:0];
    o.pos_y = py[31:0];
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got, exp_v);
    $display("mismatch %s: got %h expected %h", what, got, exp_v);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    twodo_pkg::out_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pose.size() == 0) begin
        report_mismatch("unexpected word", out_word.pos_x, '0);
      end else begin
        e = expected_pose.pop_front();
        if (out_word.pos_x !== e.pos_x) report_mismatch("pos_x", out_word.pos_x, e.pos_x);
        if (out_word.pos_y !== e.pos_y) report_mismatch("pos_y", out_word.pos_y, e.pos_y);
        if (out_word.heading_out !== e.heading_out)
          report_mismatch("heading_out", out_word.heading_out, e.heading_out);
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // valid stays high after a word so the next one can follow directly
  task automatic send_word(input twodo_pkg::in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_word <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_pose.push_back(predict_pose(w));
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input longint val);
    while (expected_pose.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[twodo_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == twodo_pkg::CFG_DIST) dist_per_deg = val & 64'hFFFF;
    else back_off = val & 64'h1FFFFF;
  endtask

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000)) - 1000);
      default: return 32'($signed($urandom_range(200000)) - 100000);
    endcase
  endfunction

  task automatic random_phase(input int n, input int sidle, input int rstall);
    twodo_pkg::in_t w;
    logic [255:0] raw;
    longint al = 0, ar = 0, ab = 0, ah = 0;
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int i = 0; i < n; i++) begin
      raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom()};
      w = raw[$bits(twodo_pkg::in_t)-1:0];
      if ($urandom_range(9) == 0) begin
        w.opcode = twodo_pkg::OP_SET_POSE;
        if ($urandom_range(1)) begin
          w.new_x = 32'($signed($urandom_range(20000000)) - 10000000);
          w.new_y = 32'($signed($urandom_range(20000000)) - 10000000);
        end
      end else if ($urandom_range(9) != 0) begin
        // plausible motion: small steps from the last reading
        w.opcode = twodo_pkg::OP_SAMPLE;
        al = last_l + $signed($urandom_range(400)) - 200;
        ar = last_r + $signed($urandom_range(400)) - 200;
        ab = last_b + $signed($urandom_range(400)) - 200;
        ah = last_h + $signed($urandom_range(60000)) - 30000;
        w.left_angle = al[31:0];
        w.right_angle = ar[31:0];
        w.back_angle = ab[31:0];
        w.heading = ah[31:0];
      end else begin
        w.opcode = twodo_pkg::OP_SAMPLE;
        w.left_angle = rand_angle();
        w.right_angle = rand_angle();
        w.back_angle = rand_angle();
      end
      send_word(w);
    end
    in_valid <= 1'b0;
  endtask

  typedef struct {
    twodo_pkg::in_t w;
    bit known;
    twodo_pkg::out_t res;
  } vector_t;

  initial begin
    vector_t vec[$];
    twodo_pkg::in_t w;
    dist_per_deg = 1573;
    back_off = 327680;
    last_l = 0; last_r = 0; last_b = 0; last_h = 0; px = 0; py = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    w = '0; w.opcode = twodo_pkg::OP_SAMPLE;
    vec.push_back('{w, 1, '{32'sd0, 32'sd0, 32'sd0}});
    w = '0; w.opcode = twodo_pkg::OP_SET_POSE; w.new_x = 32'sh7fffffff;
    w.new_y = 32'sh80000000;
    w.new_heading = 32'sd102944; w.heading = 32'sh12345678;
    vec.push_back('{w, 1, '{32'sh7fffffff, 32'sh80000000, 32'sd102944}});
    w = '0; w.left_angle = 32'sd100000; w.right_angle = 32'sd100000; w.heading = 32'sd102944;
    vec.push_back('{w, 0, '0});
    w = '0; w.opcode = twodo_pkg::OP_SET_POSE;
    vec.push_back('{w, 1, '{32'sd0, 32'sd0, 32'sd0}});
    w = '0; w.left_angle = 32'sh7fffffff; w.right_angle = 32'sh80000000;
    w.back_angle = 32'sh80000000; w.heading = 32'sh7fffffff;
    vec.push_back('{w, 0, '0});
    w = '0; w.left_angle = 32'sh80000000; w.right_angle = 32'sh80000000;
    w.back_angle = 32'sh7fffffff; w.heading = 32'sh80000000;
    vec.push_back('{w, 0, '0});
    w = '0; w.left_angle = 32'sh7fffffff; w.right_angle = 32'sh7fffffff;
    w.back_angle = 32'sh80000000; w.heading = 32'sh7fffffff;
    vec.push_back('{w, 0, '0});
    w = '0; w.opcode = twodo_pkg::OP_SET_POSE; w.new_heading = 32'sh7fffffff;
    w.left_angle = 32'sd50;
    vec.push_back('{w, 0, '0});
    w = '0; w.left_angle = 32'sd360; w.right_angle = -32'sd360; w.back_angle = 32'sd90;
    w.heading = -32'sd205887;
    vec.push_back('{w, 0, '0});
    w = '0; w.left_angle = 32'sd720; w.right_angle = 32'sd1; w.heading = 32'sd411775;
    vec.push_back('{w, 0, '0});
    foreach (vec[i]) begin
      send_word(vec[i].w);
      if (vec[i].known && expected_pose[$] !== vec[i].res)
        report_mismatch("table row", expected_pose[$].pos_x, vec[i].res.pos_x);
    end
    in_valid <= 1'b0;

    write_reg(twodo_pkg::CFG_DIST, 65535);
    write_reg(twodo_pkg::CFG_BACK_OFFSET, 1310720);
    random_phase(300, 0, 0);
    write_reg(twodo_pkg::CFG_DIST, 0);
    write_reg(twodo_pkg::CFG_BACK_OFFSET, 2097151);
    random_phase(100, 87, 0);
    write_reg(twodo_pkg::CFG_DIST, 1);
    write_reg(twodo_pkg::CFG_BACK_OFFSET, 0);
    random_phase(200, 0, 87);
    write_reg(twodo_pkg::CFG_DIST, 1573);
    write_reg(twodo_pkg::CFG_BACK_OFFSET, 327680);
    random_phase(250, 27, 27);

    // long receiver hold-off while words keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      random_phase(30, 0, 0);
    join
    write_reg(twodo_pkg::CFG_DIST, $urandom_range(65535, 1));
    write_reg(twodo_pkg::CFG_BACK_OFFSET, $urandom_range(1310720));
    random_phase(550, $urandom_range(40), $urandom_range(40));

    while (expected_pose.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+sv
sv/twodo_pkg.sv
sv/twodo_queue.sv
sv/twodo_back.sv
sv/tracking_wheel_odometry_core.sv
tb/sv/tracking_wheel_odometry_core_test.sv
